/* rtl/fbblend_pkg.sv */
// Shared types and constants for the framebuffer alpha blend store.
`default_nettype none

package fbblend_pkg;

    // Screen geometry
    localparam int SCREEN_W = 800;
    localparam int SCREEN_H = 600;
    localparam int DEPTH    = SCREEN_W * SCREEN_H;
    localparam int ADDR_W   = $clog2(DEPTH);
    // Width of x + SCREEN_W * y before truncation to the address width
    localparam int LIN_W    = 20;

    localparam int COORD_W  = 10;
    localparam int PIXEL_W  = 32;

    // Alpha byte of every blended pixel
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Operation codes; the spare code behaves as a read
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [PIXEL_W-1:0] colour;
    } in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               out_of_range;
    } out_t;

endpackage

`default_nettype wire

/* rtl/framebuffer_alpha_blend_store.sv */
// Framebuffer pixel store with read, write and source-over blend access.
//
// Input channel s_valid/s_ready/s_payload carries one access (func, pos_x,
// pos_y, colour); the result channel m_valid/m_ready/m_payload returns one
// transfer per access: the pixel read or stored, and an out_of_range flag.
// The store is one single-port RAM of 800 x 600 words with registered read
// data; its contents are undefined until written.
// One access is in flight at a time. A write or an off-screen access loads its
// result in the access step; a read or blend goes through the access step (RAM
// read), the read step (multiply) and the finish step (divide, and write back
// for a blend), which loads the result. A new input is taken only once the
// sequencer has returned to idle, so the store does not take a new access
// before it is through with the last one.
// The result sits in an output register: the next input is accepted while
// it waits. A stalled receiver holds the sequencer at its final step until
// the output register is free; nothing is dropped.
// Reset (aresetn low, synchronous) clears the sequencer and the output valid;
// the RAM is not cleared.
`default_nettype none

module framebuffer_alpha_blend_store (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire fbblend_pkg::in_t  s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fbblend_pkg::out_t      m_payload
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCESS = 4'b0010,
        ST_READ   = 4'b0100,
        ST_FIN    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                       op_reg;
    logic [fbblend_pkg::PIXEL_W-1:0]  colour_reg;
    logic [fbblend_pkg::ADDR_W-1:0]   addr_reg;
    logic                             oor_reg;
    logic [fbblend_pkg::PIXEL_W-1:0]  dst_reg;

    logic                             m_valid_reg, m_valid_next;
    fbblend_pkg::out_t                m_data_reg, m_data_next;

    logic [fbblend_pkg::LIN_W-1:0]    lin_addr;
    logic                             oor_in;
    logic                             s_xfer;
    logic                             out_free;
    logic                             out_load;

    logic                             ram_en;
    logic                             ram_we;
    logic [fbblend_pkg::PIXEL_W-1:0]  ram_wdata;
    logic [fbblend_pkg::PIXEL_W-1:0]  ram_rdata;
    logic [fbblend_pkg::PIXEL_W-1:0]  mix_pixel;
    logic                             mix_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Linear address and screen bounds from the incoming coordinates
    assign lin_addr = fbblend_pkg::LIN_W'(s_payload.pos_x)
                    + fbblend_pkg::LIN_W'(fbblend_pkg::SCREEN_W)
                    * fbblend_pkg::LIN_W'(s_payload.pos_y);
    assign oor_in   = ({1'b0, s_payload.pos_x} >=
                       (fbblend_pkg::COORD_W + 1)'(fbblend_pkg::SCREEN_W))
                   || ({1'b0, s_payload.pos_y} >=
                       (fbblend_pkg::COORD_W + 1)'(fbblend_pkg::SCREEN_H));

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg     <= s_payload.func;
            colour_reg <= s_payload.colour;
            addr_reg   <= lin_addr[fbblend_pkg::ADDR_W-1:0];
            oor_reg    <= oor_in;
        end
        if (state_reg == ST_READ) begin
            dst_reg <= ram_rdata;
        end
    end

    // Sequencer and RAM port control
    always_comb begin
        state_next  = state_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = colour_reg;
        out_load    = 1'b0;
        m_data_next = m_data_reg;
        mix_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                priority if (oor_reg) begin
                    if (out_free) begin
                        out_load                 = 1'b1;
                        m_data_next.pixel        = '0;
                        m_data_next.out_of_range = 1'b1;
                        state_next               = ST_IDLE;
                    end
                end else if (op_reg == fbblend_pkg::OP_WRITE) begin
                    if (out_free) begin
                        ram_en                   = 1'b1;
                        ram_we                   = 1'b1;
                        out_load                 = 1'b1;
                        m_data_next.pixel        = colour_reg;
                        m_data_next.out_of_range = 1'b0;
                        state_next               = ST_IDLE;
                    end
                end else begin
                    ram_en     = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                mix_load   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    m_data_next.out_of_range = 1'b0;
                    if (op_reg == fbblend_pkg::OP_BLEND) begin
                        ram_en            = 1'b1;
                        ram_we            = 1'b1;
                        ram_wdata         = mix_pixel;
                        m_data_next.pixel = mix_pixel;
                    end else begin
                        m_data_next.pixel = dst_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    fbblend_ram #(
        .WIDTH (fbblend_pkg::PIXEL_W),
        .DEPTH (fbblend_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fbblend_mix u_mix (
        .aclk  (aclk),
        .load  (mix_load),
        .src   (colour_reg),
        .dst   (ram_rdata),
        .pixel (mix_pixel)
    );

    // Off-screen accesses never touch the store
    a_no_write_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !oor_reg)
        else $error("store written for an off-screen access");

    // A flagged result carries a zero pixel
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.out_of_range) |-> (m_payload.pixel == '0))
        else $error("off-screen result with non-zero pixel");

    // A result only appears after a finishing step of the sequencer
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
            ($past(state_reg) == ST_ACCESS || $past(state_reg) == ST_FIN))
        else $error("result raised outside a finishing step");

    // RAM read data is consumed in the cycle after the read
    a_read_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_FIN))
        else $error("read step not followed by finish step");

    // No new input while an access is still in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_ready)
        else $error("input accepted twice in a row");

endmodule

`default_nettype wire

/* rtl/fbblend_ram.sv */
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module fbblend_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write, or read into the output register
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/fbblend_mix.sv */
// Source-over colour mixer: registered products, then divide by 255 and pack.
`default_nettype none

module fbblend_mix (
    input  wire logic                           aclk,
    input  wire logic                           load,
    input  wire logic [fbblend_pkg::PIXEL_W-1:0] src,
    input  wire logic [fbblend_pkg::PIXEL_W-1:0] dst,
    output logic      [fbblend_pkg::PIXEL_W-1:0] pixel
);

    logic [7:0]  alpha;
    logic [7:0]  alpha_inv;
    logic [16:0] sum_next [3];
    logic [16:0] sum_reg  [3];
    logic [7:0]  chan     [3];

    assign alpha     = src[31:24];
    assign alpha_inv = 8'hFF - alpha;

    // Weighted sums per channel: blue in lane 0, green 1, red 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_next[i] = 17'(16'(src[8*i +: 8]) * 16'(alpha))
                        + 17'(16'(dst[8*i +: 8]) * 16'(alpha_inv));
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sum_reg <= sum_next;
        end
    end

    // floor(v / 255) for v up to 255*255: (v + 1 + (v >> 8)) >> 8
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            chan[i] = 8'((sum_reg[i] + 17'd1 + (sum_reg[i] >> 8)) >> 8);
        end
    end

    assign pixel = {fbblend_pkg::ALPHA_OPAQUE, chan[2], chan[1], chan[0]};

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the framebuffer alpha blend store with a shadow store.
`timescale 1ns / 1ps

class blend_scoreboard;
    localparam int MAX_REPORTS = 10;

    // Shadow copy of every pixel written so far, keyed by linear address
    logic [31:0] shadow_px [int unsigned];
    fbblend_pkg::out_t pending_results [$];

    int n_errors;
    int n_checked;
    int n_reads;
    int n_writes;
    int n_blends;
    int n_off;

    // Source-over mix of src onto dst, alpha byte forced opaque
    function logic [31:0] blend_over(logic [31:0] src, logic [31:0] dst);
        int unsigned a;
        int unsigned s;
        int unsigned d;
        int unsigned mixed;
        logic [31:0] res;
        a   = 32'(src[31:24]);
        res = 32'hFF00_0000;
        for (int k = 0; k < 3; k++) begin
            s     = (src >> (8 * k)) & 32'hFF;
            d     = (dst >> (8 * k)) & 32'hFF;
            mixed = (s * a + d * (255 - a)) / 255;
            res[8*k +: 8] = mixed[7:0];
        end
        return res;
    endfunction

    // Accepted input transfer: update shadow store, queue the expected result
    function void note_access(fbblend_pkg::in_t acc);
        fbblend_pkg::out_t want;
        int unsigned addr;
        logic [31:0] old_px;
        want = '0;
        if (acc.pos_x >= fbblend_pkg::SCREEN_W
                || acc.pos_y >= fbblend_pkg::SCREEN_H) begin
            want.out_of_range = 1'b1;
            n_off++;
        end else begin
            addr   = acc.pos_x + fbblend_pkg::SCREEN_W * acc.pos_y;
            old_px = shadow_px.exists(addr) ? shadow_px[addr] : 32'h0;
            case (acc.func)
                fbblend_pkg::OP_WRITE: begin
                    shadow_px[addr] = acc.colour;
                    n_writes++;
                end
                fbblend_pkg::OP_BLEND: begin
                    shadow_px[addr] = blend_over(acc.colour, old_px);
                    n_blends++;
                end
                default: begin
                    n_reads++;
                end
            endcase
            want.pixel = shadow_px.exists(addr) ? shadow_px[addr] : 32'h0;
        end
        pending_results.push_back(want);
    endfunction

    function void flag_error(string what);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("tb: %s", what);
    endfunction

    // Accepted result transfer: compare against the oldest expectation
    function void check_result(fbblend_pkg::out_t got);
        fbblend_pkg::out_t want;
        if (pending_results.size() == 0) begin
            flag_error($sformatf("result with nothing pending: pixel %h off-screen %b",
                                 got.pixel, got.out_of_range));
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        if (got.pixel !== want.pixel || got.out_of_range !== want.out_of_range)
            flag_error($sformatf({"mismatch on result %0d: pixel exp %h got %h, ",
                                  "off-screen exp %b got %b"},
                                 n_checked, want.pixel, got.pixel,
                                 want.out_of_range, got.out_of_range));
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module tb_top;
    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int COORD_MAX          = (1 << fbblend_pkg::COORD_W) - 1;
    localparam int RANDOM_PER_PHASE   = 510;
    localparam int HOLD_CYCLES        = 400;
    localparam int STALL_LIMIT        = 5000;
    localparam int DRAIN_CYCLES       = 10;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    fbblend_pkg::in_t  s_payload;
    logic              m_valid;
    logic              m_ready;
    fbblend_pkg::out_t m_payload;

    blend_scoreboard sb;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_armed;
    bit hold_done;

    // Pixels already written, so reads and blends only touch defined entries
    bit          is_written [int unsigned];
    logic [19:0] written_xy [$];

    int unsigned stall_cycles;

    framebuffer_alpha_blend_store u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #5 aclk = ~aclk;

    // Offer one access, wait for its transfer and hand it to the scoreboard
    task automatic push_access(input logic [1:0] func, input logic [9:0] x,
                               input logic [9:0] y, input logic [31:0] colour);
        fbblend_pkg::in_t acc;
        int unsigned key;
        acc.func   = func;
        acc.pos_x  = x;
        acc.pos_y  = y;
        acc.colour = colour;
        if (func == fbblend_pkg::OP_WRITE && x < fbblend_pkg::SCREEN_W
                && y < fbblend_pkg::SCREEN_H) begin
            key = x + fbblend_pkg::SCREEN_W * y;
            if (!is_written.exists(key)) begin
                is_written[key] = 1'b1;
                written_xy.push_back({x, y});
            end
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= acc;
        do @(posedge aclk); while (!s_ready);
        sb.note_access(acc);
    endtask

    // Random access: writes, mostly into a small hot patch, reads and blends of
    // written pixels, some off-screen accesses of every kind
    task automatic push_random_access();
        int unsigned r;
        int unsigned idx;
        logic [1:0]  func;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [31:0] colour;
        r      = $urandom_range(99);
        colour = $urandom;
        if (r < 12 || written_xy.size() == 0) begin
            func = 2'($urandom_range(3));
            case ($urandom_range(2))
                0: begin
                    x = 10'($urandom_range(COORD_MAX, fbblend_pkg::SCREEN_W));
                    y = 10'($urandom_range(COORD_MAX));
                end
                1: begin
                    x = 10'($urandom_range(COORD_MAX));
                    y = 10'($urandom_range(COORD_MAX, fbblend_pkg::SCREEN_H));
                end
                default: begin
                    x = 10'($urandom_range(COORD_MAX, fbblend_pkg::SCREEN_W));
                    y = 10'($urandom_range(COORD_MAX, fbblend_pkg::SCREEN_H));
                end
            endcase
        end else if (r < 45) begin
            func = fbblend_pkg::OP_WRITE;
            case ($urandom_range(9))
                0, 1: begin
                    x = 10'($urandom_range(fbblend_pkg::SCREEN_W - 1));
                    y = 10'($urandom_range(fbblend_pkg::SCREEN_H - 1));
                end
                2: begin
                    x = $urandom_range(1) ? 10'(fbblend_pkg::SCREEN_W - 1) : 10'd0;
                    y = $urandom_range(1) ? 10'(fbblend_pkg::SCREEN_H - 1) : 10'd0;
                end
                default: begin
                    x = 10'($urandom_range(15));
                    y = 10'($urandom_range(7));
                end
            endcase
        end else begin
            idx    = $urandom_range(written_xy.size() - 1);
            {x, y} = written_xy[idx];
            if (r < 72) begin
                func = ($urandom_range(4) == 0) ? OP_SPARE : fbblend_pkg::OP_READ;
            end else begin
                func = fbblend_pkg::OP_BLEND;
                case ($urandom_range(6))
                    0: colour[31:24] = 8'h00;
                    1: colour[31:24] = 8'hFF;
                    default: ;
                endcase
            end
        end
        push_access(func, x, y, colour);
    endtask

    // Result side: random back-pressure, one long hold while the sender keeps going
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_armed && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge aclk);
                if (m_valid && m_ready)
                    sb.check_result(m_payload);
            end
        end
    end

    // Watchdog: no transfer on either side for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_payload     <= '0;
        hold_armed    = 1'b0;
        hold_done     = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 72;
        sb            = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Corners, every operation, alpha extremes and off-screen handling
        push_access(fbblend_pkg::OP_WRITE, 0, 0, 32'hFFFF_FFFF);
        push_access(fbblend_pkg::OP_READ, 0, 0, 32'h0000_0000);
        push_access(fbblend_pkg::OP_WRITE, 799, 599, 32'h0000_0000);
        push_access(OP_SPARE, 799, 599, 32'hFFFF_FFFF);
        push_access(fbblend_pkg::OP_BLEND, 0, 0, 32'h00AB_CDEF);
        push_access(fbblend_pkg::OP_BLEND, 799, 599, 32'hFF12_3456);
        push_access(fbblend_pkg::OP_WRITE, 799, 0, 32'h80A0_B0C0);
        push_access(fbblend_pkg::OP_BLEND, 799, 0, 32'h7F10_2030);
        push_access(fbblend_pkg::OP_READ, 799, 0, 32'h0000_0000);
        // Off-screen write whose folded address would land on (0,1)
        push_access(fbblend_pkg::OP_WRITE, 0, 1, 32'h5A5A_5A5A);
        push_access(fbblend_pkg::OP_WRITE, 800, 0, 32'hDEAD_BEEF);
        push_access(fbblend_pkg::OP_READ, 0, 1, 32'h0000_0000);
        push_access(fbblend_pkg::OP_BLEND, 1023, 1023, 32'hFFFF_FFFF);
        push_access(fbblend_pkg::OP_READ, 0, 600, 32'h0000_0000);
        push_access(OP_SPARE, 1023, 0, 32'h1234_5678);
        push_access(fbblend_pkg::OP_WRITE, 0, 599, 32'hFFFF_FFFF);
        push_access(fbblend_pkg::OP_BLEND, 0, 599, 32'h8000_0000);
        push_access(fbblend_pkg::OP_READ, 0, 599, 32'h0000_0000);
        push_access(fbblend_pkg::OP_WRITE, 512, 300, 32'hA5C3_E1F0);
        push_access(fbblend_pkg::OP_BLEND, 512, 300, 32'h01FF_FFFF);
        push_access(fbblend_pkg::OP_READ, 512, 300, 32'h0000_0000);

        // Three stall patterns: slow receiver, slow sender, then full rate
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (ph == 2 && i == 60)
                    hold_armed = 1'b1;
                push_random_access();
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d writes, %0d reads, %0d blends, %0d off-screen accesses",
                 sb.n_writes, sb.n_reads, sb.n_blends, sb.n_off);
        $display({"summary: %0d results compared over three stall patterns ",
                  "and a %0d-cycle hold, %0d errors"},
                 sb.n_checked, HOLD_CYCLES, sb.n_errors);
        if (sb.n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* framebuffer_alpha_blend_store.f */
rtl/fbblend_pkg.sv
rtl/fbblend_ram.sv
rtl/fbblend_mix.sv
rtl/framebuffer_alpha_blend_store.sv
tb/tb_top.sv
